// ----- src/awbg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants for the AWB gain seed and ratio block.
// Used by the scale unit, the gain and ratio lanes and the top level.
package awbg_pkg;

  localparam int PHYS_W     = 16;
  localparam int GAIN_W     = 15;
  localparam int BL_W       = 12;
  localparam int SCALE_W    = 21;
  localparam int RATIO_W    = 16;
  localparam int PACKED_W   = 32;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CNT_W      = 3;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 15'h7fff;

  localparam logic [CNT_W-1:0] SCALE_STEPS = 3'd6;
  localparam logic [CNT_W-1:0] GAIN_STEPS  = 3'd5;
  localparam logic [CNT_W-1:0] RATIO_STEPS = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_BAYER_PHASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LEVEL_D = 3'd4;

  typedef struct packed {
    logic load;
    logic run;
  } lane_ctl_t;

  // Physical slot for each logical channel, channel 0 in the low bits.
  function automatic logic [5:0] chan_row(input logic [PHASE_W-1:0] phase);
    logic [5:0] row;
    case (phase)
      2'd0:    row = {2'd3, 2'd1, 2'd0};
      2'd1:    row = {2'd2, 2'd0, 2'd1};
      2'd2:    row = {2'd0, 2'd2, 2'd3};
      2'd3:    row = {2'd1, 2'd3, 2'd2};
      default: row = {2'd3, 2'd1, 2'd0};
    endcase
    return row;
  endfunction

endpackage

// ----- src/awbg_scale_unit.sv -----
`timescale 1ns / 1ps
// Scale divider: scale = 2^20 / (4096 - avg black level), four bits per cycle.
// Depends on awbg_pkg.
module awbg_scale_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [awbg_pkg::BL_W-1:0]     black_level_a,
  input  logic [awbg_pkg::BL_W-1:0]     black_level_b,
  input  logic [awbg_pkg::BL_W-1:0]     black_level_c,
  input  logic [awbg_pkg::BL_W-1:0]     black_level_d,
  output logic                          busy,
  output logic [awbg_pkg::SCALE_W-1:0]  scale
);

  logic                         running;
  logic [awbg_pkg::CNT_W-1:0]   cnt;
  logic [11:0]                  rem;
  logic [11:0]                  rem_next;
  logic [23:0]                  quo;
  logic [23:0]                  quo_next;
  logic [12:0]                  den;
  logic [13:0]                  bl_sum;
  logic [12:0]                  den_start;

  assign bl_sum = {2'd0, black_level_a} + {2'd0, black_level_b}
                + {2'd0, black_level_c} + {2'd0, black_level_d};
  assign den_start = 13'h1000 - {1'b0, bl_sum[13:2]};

  always_comb begin
    logic [12:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < 4; k++) begin
      trial = {rem_next, quo_next[23]};
      quo_next = {quo_next[22:0], 1'b0};
      if (trial >= den) begin
        rem_next = 12'(trial - den);
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= awbg_pkg::SCALE_STEPS;
      rem     <= '0;
      quo     <= 24'h100000;
      den     <= den_start;
    end else if (running) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt - 3'd1;
      if (cnt == 3'd1) begin
        running <= 1'b0;
      end
    end
  end

  assign busy  = running;
  assign scale = quo[awbg_pkg::SCALE_W-1:0];

endmodule

// ----- src/awbg_gain_lane.sv -----
`timescale 1ns / 1ps
// One channel lane: gain = (phys*256 + scale/2) / scale, saturated, four bits per cycle.
// Depends on awbg_pkg.
module awbg_gain_lane (
  input  logic                          clk,
  input  awbg_pkg::lane_ctl_t           ctl,
  input  logic [awbg_pkg::PHYS_W-1:0]   phys,
  input  logic [awbg_pkg::SCALE_W-1:0]  scale,
  output logic [awbg_pkg::GAIN_W-1:0]   gain
);

  logic [20:0] rem;
  logic [20:0] rem_next;
  logic [19:0] quo;
  logic [19:0] quo_next;
  logic [20:0] den;
  logic [24:0] num;

  assign num = {1'b0, phys, 8'd0} + {5'd0, scale[20:1]};

  always_comb begin
    logic [21:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < 4; k++) begin
      trial = {rem_next, quo_next[19]};
      quo_next = {quo_next[18:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_next = 21'(trial - {1'b0, den});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[20:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= {16'd0, num[24:20]};
      quo <= num[19:0];
      den <= scale;
    end else if (ctl.run) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign gain = (quo > {5'd0, awbg_pkg::GAIN_MAX}) ? awbg_pkg::GAIN_MAX : quo[14:0];

endmodule

// ----- src/awbg_ratio_lane.sv -----
`timescale 1ns / 1ps
// Ratio lane: low 16 bits of num_gain*4096 / den_gain, four bits per cycle.
// Depends on awbg_pkg.
module awbg_ratio_lane (
  input  logic                          clk,
  input  awbg_pkg::lane_ctl_t           ctl,
  input  logic [awbg_pkg::GAIN_W-1:0]   num_gain,
  input  logic [awbg_pkg::GAIN_W-1:0]   den_gain,
  output logic [awbg_pkg::RATIO_W-1:0]  ratio,
  output logic                          ratio_valid
);

  logic [14:0] rem;
  logic [14:0] rem_next;
  logic [27:0] quo;
  logic [27:0] quo_next;
  logic [14:0] den;

  always_comb begin
    logic [15:0] trial;
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < 4; k++) begin
      trial = {rem_next, quo_next[27]};
      quo_next = {quo_next[26:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_next = 15'(trial - {1'b0, den});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= '0;
      quo <= {1'b0, num_gain, 12'd0};
      den <= den_gain;
    end else if (ctl.run) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign ratio_valid = (den != '0);
  assign ratio       = ratio_valid ? quo[15:0] : '0;

endmodule

// ----- src/awb_gain_seed_and_ratio_core.sv -----
`timescale 1ns / 1ps
// Top level of the AWB gain seed and ratio block.
// Depends on awbg_pkg, awbg_scale_unit, awbg_gain_lane and awbg_ratio_lane.
//
// Usage:
//   Input channel: four physical gains with in_valid / in_stall. An item is
//   taken at an edge where in_valid is high and in_stall is low.
//   Output channel: three channel gains, two ratios with valid flags and the
//   packed word, with out_valid / out_stall.
//   Configuration: cfg_we, cfg_index, cfg_data; written at any edge with cfg_we
//   high. The user must write only while no item is in flight; the block does not enforce it.
//   Path: three gain lanes divide in 5 four-bit steps, then two ratio lanes
//   divide in 7 four-bit steps before the result enters the output register.
//   Overlap: the ratio lanes set the pace; the gain lanes take the next item
//   while the ratio lanes work on the previous one.
//   Reset: configuration clears to zero and the scale divider runs, holding
//   in_stall high. Any configuration write restarts it the same way.
//   A stalled result holds in the output register; the lanes behind it hold
//   and in_stall rises once the gain lanes are full.
module awb_gain_seed_and_ratio_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [awbg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [awbg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [awbg_pkg::PHYS_W-1:0]       phys_gain_0,
  input  logic [awbg_pkg::PHYS_W-1:0]       phys_gain_1,
  input  logic [awbg_pkg::PHYS_W-1:0]       phys_gain_2,
  input  logic [awbg_pkg::PHYS_W-1:0]       phys_gain_3,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [awbg_pkg::GAIN_W-1:0]       chan0_gain,
  output logic [awbg_pkg::GAIN_W-1:0]       chan1_gain,
  output logic [awbg_pkg::GAIN_W-1:0]       chan2_gain,
  output logic [awbg_pkg::RATIO_W-1:0]      ratio_over_chan2,
  output logic                              ratio_over_chan2_valid,
  output logic [awbg_pkg::RATIO_W-1:0]      ratio_over_chan0,
  output logic                              ratio_over_chan0_valid,
  output logic [awbg_pkg::PACKED_W-1:0]     packed_gains
);

  logic [awbg_pkg::PHASE_W-1:0]   bayer_phase;
  logic [awbg_pkg::BL_W-1:0]      black_level_a;
  logic [awbg_pkg::BL_W-1:0]      black_level_b;
  logic [awbg_pkg::BL_W-1:0]      black_level_c;
  logic [awbg_pkg::BL_W-1:0]      black_level_d;
  logic                           dirty;
  logic                           scale_run;
  logic                           scale_busy;
  logic [awbg_pkg::SCALE_W-1:0]   scale;

  logic                           in_accept;
  logic                           a_valid;
  logic [awbg_pkg::CNT_W-1:0]     a_cnt;
  logic                           a_done;
  logic                           b_valid;
  logic [awbg_pkg::CNT_W-1:0]     b_cnt;
  logic                           b_done;
  logic                           b_load;
  logic                           b_move;
  logic                           out_free;

  awbg_pkg::lane_ctl_t            gain_ctl;
  awbg_pkg::lane_ctl_t            ratio_ctl;

  logic [3:0][awbg_pkg::PHYS_W-1:0] phys_all;
  logic [5:0]                       row;
  logic [2:0][awbg_pkg::GAIN_W-1:0] lane_gain;
  logic [2:0][awbg_pkg::GAIN_W-1:0] b_gain;
  logic [awbg_pkg::RATIO_W-1:0]     ratio2;
  logic                             ratio2_valid;
  logic [awbg_pkg::RATIO_W-1:0]     ratio0;
  logic                             ratio0_valid;
  logic [awbg_pkg::PACKED_W-1:0]    packed_sum;

  awbg_scale_unit u_scale (
    .clk           (clk),
    .rst           (rst),
    .start         (dirty),
    .black_level_a (black_level_a),
    .black_level_b (black_level_b),
    .black_level_c (black_level_c),
    .black_level_d (black_level_d),
    .busy          (scale_run),
    .scale         (scale)
  );

  assign scale_busy = dirty || scale_run;

  assign a_done    = a_valid && (a_cnt == '0);
  assign b_done    = b_valid && (b_cnt == '0);
  assign out_free  = !out_valid || !out_stall;
  assign b_move    = b_done && out_free;
  assign b_load    = a_done && (!b_valid || b_move);
  assign in_stall  = scale_busy || (a_valid && !b_load);
  assign in_accept = in_valid && !in_stall;

  assign gain_ctl.load  = in_accept;
  assign gain_ctl.run   = a_valid && (a_cnt != '0);
  assign ratio_ctl.load = b_load;
  assign ratio_ctl.run  = b_valid && (b_cnt != '0);

  assign phys_all = {phys_gain_3, phys_gain_2, phys_gain_1, phys_gain_0};
  assign row      = awbg_pkg::chan_row(bayer_phase);

  for (genvar i = 0; i < 3; i++) begin : g_gain_lane
    awbg_gain_lane u_lane (
      .clk   (clk),
      .ctl   (gain_ctl),
      .phys  (phys_all[row[2*i +: 2]]),
      .scale (scale),
      .gain  (lane_gain[i])
    );
  end

  awbg_ratio_lane u_ratio_over_chan2 (
    .clk         (clk),
    .ctl         (ratio_ctl),
    .num_gain    (lane_gain[1]),
    .den_gain    (lane_gain[2]),
    .ratio       (ratio2),
    .ratio_valid (ratio2_valid)
  );

  awbg_ratio_lane u_ratio_over_chan0 (
    .clk         (clk),
    .ctl         (ratio_ctl),
    .num_gain    (lane_gain[1]),
    .den_gain    (lane_gain[0]),
    .ratio       (ratio0),
    .ratio_valid (ratio0_valid)
  );

  assign packed_sum = {20'd0, b_gain[0][14:3]}
                    + {10'd0, b_gain[1][14:3], 10'd0}
                    + {b_gain[2][14:3], 20'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      bayer_phase   <= '0;
      black_level_a <= '0;
      black_level_b <= '0;
      black_level_c <= '0;
      black_level_d <= '0;
      dirty         <= 1'b1;
      a_valid       <= 1'b0;
      a_cnt         <= '0;
      b_valid       <= 1'b0;
      b_cnt         <= '0;
      out_valid     <= 1'b0;
    end else begin
      dirty <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          awbg_pkg::CFG_BAYER_PHASE:   bayer_phase   <= cfg_data[awbg_pkg::PHASE_W-1:0];
          awbg_pkg::CFG_BLACK_LEVEL_A: black_level_a <= cfg_data;
          awbg_pkg::CFG_BLACK_LEVEL_B: black_level_b <= cfg_data;
          awbg_pkg::CFG_BLACK_LEVEL_C: black_level_c <= cfg_data;
          awbg_pkg::CFG_BLACK_LEVEL_D: black_level_d <= cfg_data;
          default: ;
        endcase
      end

      if (in_accept) begin
        a_valid <= 1'b1;
        a_cnt   <= awbg_pkg::GAIN_STEPS;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end else if (gain_ctl.run) begin
        a_cnt <= a_cnt - 3'd1;
      end

      if (b_load) begin
        b_valid <= 1'b1;
        b_cnt   <= awbg_pkg::RATIO_STEPS;
        b_gain  <= lane_gain;
      end else if (b_move) begin
        b_valid <= 1'b0;
      end else if (ratio_ctl.run) begin
        b_cnt <= b_cnt - 3'd1;
      end

      if (b_move) begin
        out_valid              <= 1'b1;
        chan0_gain             <= b_gain[0];
        chan1_gain             <= b_gain[1];
        chan2_gain             <= b_gain[2];
        ratio_over_chan2       <= ratio2;
        ratio_over_chan2_valid <= ratio2_valid;
        ratio_over_chan0       <= ratio0;
        ratio_over_chan0_valid <= ratio0_valid;
        packed_gains           <= packed_sum;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for awb_gain_seed_and_ratio_core: directed and random gain sets
// under several black-level and Bayer phase settings, with random idling on both sides.
// Depends on awbg_pkg; a scoreboard class predicts each result from its own register copy.
module testbench;

  localparam int LIMIT = 600000;
  localparam int RANDOM_ROUNDS = 11;
  localparam int ROUND_ITEMS = 150;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [awbg_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic [awbg_pkg::GAIN_W-1:0]   chan0;
    logic [awbg_pkg::GAIN_W-1:0]   chan1;
    logic [awbg_pkg::GAIN_W-1:0]   chan2;
    logic [awbg_pkg::RATIO_W-1:0]  over2;
    logic                          over2_ok;
    logic [awbg_pkg::RATIO_W-1:0]  over0;
    logic                          over0_ok;
    logic [awbg_pkg::PACKED_W-1:0] packed_word;
  } gains_t;

  class gain_scoreboard;
    logic [awbg_pkg::PHASE_W-1:0] phase;
    logic [awbg_pkg::BL_W-1:0]    black [4];
    int unsigned                  slot_map [4][3];
    gains_t                       awaited [$];
    int                           errors;

    function new();
      slot_map = '{'{0, 1, 3}, '{1, 0, 2}, '{3, 2, 0}, '{2, 3, 1}};
      phase = '0;
      foreach (black[i]) black[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [awbg_pkg::CFG_IDX_W-1:0] idx,
                            logic [awbg_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        awbg_pkg::CFG_BAYER_PHASE:   phase = data[awbg_pkg::PHASE_W-1:0];
        awbg_pkg::CFG_BLACK_LEVEL_A: black[0] = data[awbg_pkg::BL_W-1:0];
        awbg_pkg::CFG_BLACK_LEVEL_B: black[1] = data[awbg_pkg::BL_W-1:0];
        awbg_pkg::CFG_BLACK_LEVEL_C: black[2] = data[awbg_pkg::BL_W-1:0];
        awbg_pkg::CFG_BLACK_LEVEL_D: black[3] = data[awbg_pkg::BL_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned ratio(int unsigned num, int unsigned den);
      if (den == 0) return 0;
      return ((num * 4096) / den) & 32'hffff;
    endfunction

    function void note_input(logic [awbg_pkg::PHYS_W-1:0] phys [4]);
      int unsigned avg, scale, g;
      int unsigned gain [3];
      gains_t r;
      avg = (black[0] + black[1] + black[2] + black[3]) >> 2;
      scale = 32'h100000 / (4096 - avg);
      for (int i = 0; i < 3; i++) begin
        g = (phys[slot_map[phase][i]] * 256 + scale / 2) / scale;
        gain[i] = (g > 32767) ? 32767 : g;
      end
      r.chan0 = awbg_pkg::GAIN_W'(gain[0]);
      r.chan1 = awbg_pkg::GAIN_W'(gain[1]);
      r.chan2 = awbg_pkg::GAIN_W'(gain[2]);
      r.over2 = awbg_pkg::RATIO_W'(ratio(gain[1], gain[2]));
      r.over2_ok = (gain[2] != 0);
      r.over0 = awbg_pkg::RATIO_W'(ratio(gain[1], gain[0]));
      r.over0_ok = (gain[0] != 0);
      r.packed_word = (gain[0] >> 3) + ((gain[1] >> 3) << 10) + ((gain[2] >> 3) << 20);
      awaited.push_back(r);
    endfunction

    function void compare(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check(gains_t got);
      gains_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, chan0 %0d chan1 %0d chan2 %0d",
                 $time, got.chan0, got.chan1, got.chan2);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare("chan0_gain", want.chan0, got.chan0);
      compare("chan1_gain", want.chan1, got.chan1);
      compare("chan2_gain", want.chan2, got.chan2);
      compare("ratio_over_chan2", want.over2, got.over2);
      compare("ratio_over_chan2_valid", want.over2_ok, got.over2_ok);
      compare("ratio_over_chan0", want.over0, got.over0);
      compare("ratio_over_chan0_valid", want.over0_ok, got.over0_ok);
      compare("packed_gains", want.packed_word, got.packed_word);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [awbg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [awbg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [awbg_pkg::PHYS_W-1:0]     phys_gain_0 = '0;
  logic [awbg_pkg::PHYS_W-1:0]     phys_gain_1 = '0;
  logic [awbg_pkg::PHYS_W-1:0]     phys_gain_2 = '0;
  logic [awbg_pkg::PHYS_W-1:0]     phys_gain_3 = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [awbg_pkg::GAIN_W-1:0]     chan0_gain, chan1_gain, chan2_gain;
  logic [awbg_pkg::RATIO_W-1:0]    ratio_over_chan2, ratio_over_chan0;
  logic                            ratio_over_chan2_valid, ratio_over_chan0_valid;
  logic [awbg_pkg::PACKED_W-1:0]   packed_gains;

  gain_scoreboard sb = new();
  logic calm = 1'b0;
  int   cycles = 0;

  awb_gain_seed_and_ratio_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .phys_gain_0(phys_gain_0), .phys_gain_1(phys_gain_1),
    .phys_gain_2(phys_gain_2), .phys_gain_3(phys_gain_3),
    .out_valid(out_valid), .out_stall(out_stall),
    .chan0_gain(chan0_gain), .chan1_gain(chan1_gain), .chan2_gain(chan2_gain),
    .ratio_over_chan2(ratio_over_chan2), .ratio_over_chan2_valid(ratio_over_chan2_valid),
    .ratio_over_chan0(ratio_over_chan0), .ratio_over_chan0_valid(ratio_over_chan0_valid),
    .packed_gains(packed_gains)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check('{chan0_gain, chan1_gain, chan2_gain, ratio_over_chan2,
                 ratio_over_chan2_valid, ratio_over_chan0, ratio_over_chan0_valid,
                 packed_gains});
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 29);
  end

  task automatic send_item(input logic [awbg_pkg::PHYS_W-1:0] g0, g1, g2, g3);
    logic [awbg_pkg::PHYS_W-1:0] phys [4];
    int gap;
    gap = 0;
    while (!calm && gap < 20 && $urandom_range(0, 99) < 29) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    phys_gain_0 <= g0;
    phys_gain_1 <= g1;
    phys_gain_2 <= g2;
    phys_gain_3 <= g3;
    do @(posedge clk); while (in_stall);
    phys = '{g0, g1, g2, g3};
    sb.note_input(phys);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [awbg_pkg::CFG_IDX_W-1:0] idx,
                         input logic [awbg_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [awbg_pkg::CFG_DATA_W-1:0] ph, a, b, c, d);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    put_reg(awbg_pkg::CFG_BAYER_PHASE, ph);
    put_reg(awbg_pkg::CFG_BLACK_LEVEL_A, a);
    put_reg(awbg_pkg::CFG_BLACK_LEVEL_B, b);
    put_reg(awbg_pkg::CFG_BLACK_LEVEL_C, c);
    put_reg(awbg_pkg::CFG_BLACK_LEVEL_D, d);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [awbg_pkg::BL_W-1:0] rand_black(int round);
    int pick;
    pick = $urandom_range(0, 99);
    if (round == 0 || pick < 25) return '0;
    if (round == 1 || pick < 45) return '1;
    return awbg_pkg::BL_W'($urandom_range(0, 4095));
  endfunction

  function automatic logic [awbg_pkg::PHYS_W-1:0] rand_gain();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return awbg_pkg::PHYS_W'($urandom_range(0, 65535));
    if (pick < 60) return awbg_pkg::PHYS_W'($urandom_range(0, 2047));
    if (pick < 72) return awbg_pkg::PHYS_W'($urandom_range(32000, 33500));
    if (pick < 82) return '0;
    return awbg_pkg::PHYS_W'(16'hffff - $urandom_range(0, 255));
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_config(12'hffc, 12'd0, 12'd0, 12'd0, 12'd0);
    put_reg(CFG_SPARE, 12'hfff);
    cfg_we <= 1'b0;
    send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(16'hffff, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'h0000, 16'hffff, 16'h0000, 16'h0000);
    send_item(16'h0000, 16'h0000, 16'hffff, 16'h0000);
    send_item(16'h0000, 16'h0000, 16'h0000, 16'hffff);
    send_item(16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send_item(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    send_item(16'h7fff, 16'h8000, 16'h0001, 16'h7fff);
    send_item(16'h0001, 16'h0001, 16'h0001, 16'h0001);

    set_config(12'd2, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(16'h07ff, 16'h0800, 16'h07ff, 16'h0800);
    send_item(16'h0000, 16'hffff, 16'h0000, 16'hffff);
    send_item(16'h1234, 16'h0000, 16'hffff, 16'h5678);

    set_config(12'd1, 12'd2048, 12'd2048, 12'd2048, 12'd2049);
    send_item(16'hffff, 16'hfffe, 16'h8000, 16'h7fff);
    send_item(16'h0100, 16'h0200, 16'h0300, 16'h0400);

    set_config(12'd3, 12'd0, 12'd4095, 12'd0, 12'd4095);
    send_item(16'h0000, 16'hffff, 16'hffff, 16'h0000);
    send_item(16'hffff, 16'h0000, 16'h0000, 16'hffff);

    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      set_config({10'($urandom_range(0, 1023)), 2'(round)},
                 rand_black(round), rand_black(round), rand_black(round), rand_black(round));
      calm = (round == 4);
      for (int n = 0; n < ROUND_ITEMS; n++) begin
        if (round == 6 && n == ROUND_ITEMS / 2) drain();
        send_item(rand_gain(), rand_gain(), rand_gain(), rand_gain());
      end
      calm = 1'b0;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
